[design/sbg_pkg.sv]
`timescale 1ns / 1ps

package sbg_pkg;

    // field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 11;
    localparam int POW_W  = 64;
    localparam int WGT_W  = 17;
    localparam int BAND_W = 7;
    localparam int HALF_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = HALF_W + WGT_W;

    // input tdata layout, lowest bit first
    localparam int SLOT_LSB  = 0;
    localparam int POWER_LSB = SLOT_LSB + IDX_W;
    localparam int LBIN_LSB  = POWER_LSB + POW_W;
    localparam int UBIN_LSB  = LBIN_LSB + IDX_W;
    localparam int LWGT_LSB  = UBIN_LSB + IDX_W;
    localparam int UWGT_LSB  = LWGT_LSB + WGT_W;
    localparam int IN_USED_W = UWGT_LSB + WGT_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OBAND_LSB  = 0;
    localparam int OPOWER_LSB = OBAND_LSB + BAND_W;
    localparam int OUT_USED_W = OPOWER_LSB + POW_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_BIN  = 2'd0,
        OP_LOAD_BAND = 2'd1,
        OP_COMPUTE   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_EDGE_RD,
        S_EDGE_GO,
        S_EDGE_WAIT,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_FIN
    } t_wphase;

    // one band table row
    typedef struct packed {
        logic [WGT_W-1:0] lo_w;
        logic [WGT_W-1:0] up_w;
        logic [IDX_W-1:0] lo_bin;
        logic [IDX_W-1:0] up_bin;
    } t_band;

    // add that clamps at all ones
    function automatic logic [POW_W-1:0] sat_add(input logic [POW_W-1:0] a,
                                                 input logic [POW_W-1:0] b);
        logic [POW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POW_W] ? {POW_W{1'b1}} : s[POW_W-1:0];
    endfunction

endpackage

[design/sbg_weigh.sv]
`timescale 1ns / 1ps

// edge weighting: (power * weight) >> 16, saturated, one shared 32x17 multiplier
module sbg_weigh (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbg_pkg::POW_W-1:0]  i_power,
    input  logic [sbg_pkg::WGT_W-1:0]  i_weight,
    output logic                       o_done,
    output logic [sbg_pkg::POW_W-1:0]  o_term
);

    logic                        r_busy;
    logic                        r_done;
    sbg_pkg::t_wphase            r_ph;
    logic [sbg_pkg::POW_W-1:0]   r_p;
    logic [sbg_pkg::WGT_W-1:0]   r_w;
    logic [sbg_pkg::PROD_W-1:0]  r_plo;
    logic [sbg_pkg::PROD_W-1:0]  r_phi;
    logic [sbg_pkg::POW_W-1:0]   r_term;

    logic [sbg_pkg::HALF_W-1:0]  mul_a;
    logic [sbg_pkg::PROD_W-1:0]  prod;
    logic [sbg_pkg::POW_W:0]     wsum;
    logic [sbg_pkg::POW_W-1:0]   wterm;

    // low half on the first pass, high half on the second
    always_comb begin
        mul_a = (r_ph == sbg_pkg::PH_LO) ? r_p[sbg_pkg::HALF_W-1:0]
                                         : r_p[sbg_pkg::POW_W-1:sbg_pkg::HALF_W];
        prod  = sbg_pkg::PROD_W'(mul_a) * sbg_pkg::PROD_W'(r_w);
    end

    // recombine partial products; high product at or above 2^48 saturates
    always_comb begin
        wsum = {1'b0, r_phi[sbg_pkg::PROD_W-2:0], {sbg_pkg::FRAC_W{1'b0}}}
             + (sbg_pkg::POW_W+1)'(r_plo[sbg_pkg::PROD_W-1:sbg_pkg::FRAC_W]);
        wterm = (r_phi[sbg_pkg::PROD_W-1] || wsum[sbg_pkg::POW_W])
              ? {sbg_pkg::POW_W{1'b1}} : wsum[sbg_pkg::POW_W-1:0];
    end

    // phase sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= sbg_pkg::PH_LO;
        end else begin
            r_done <= r_busy && (r_ph == sbg_pkg::PH_FIN);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= sbg_pkg::PH_LO;
            end else if (r_busy) begin
                case (r_ph)
                    sbg_pkg::PH_LO:  r_ph <= sbg_pkg::PH_HI;
                    sbg_pkg::PH_HI:  r_ph <= sbg_pkg::PH_FIN;
                    default: begin
                        r_busy <= 1'b0;
                        r_ph   <= sbg_pkg::PH_LO;
                    end
                endcase
            end
        end
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= i_power;
            r_w <= i_weight;
        end
        if (r_busy && r_ph == sbg_pkg::PH_LO) begin
            r_plo <= prod;
        end
        if (r_busy && r_ph == sbg_pkg::PH_HI) begin
            r_phi <= prod;
        end
        if (r_busy && r_ph == sbg_pkg::PH_FIN) begin
            r_term <= wterm;
        end
    end

    assign o_done = r_done;
    assign o_term = r_term;

endmodule

[design/spectral_band_grouping_top.sv]
`timescale 1ns / 1ps
// load items (bin or band table entry) are written while idle, without leaving idle
// a compute item reads its table row, weighs the lower then the upper edge, then sums any
// interior bins: one bin store read a cycle and a shared 32x17
// multiplier (two passes per edge); a stalled output holds the block, next item taken then
// reset: synchronous, active low; clears control and the output valid,
// output payload, bin store and band table are undefined until written
module spectral_band_grouping_top #(
    parameter int FFT_POINTS = 2048,
    parameter int MAX_BANDS  = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot, bin_power, lower_bin, upper_bin, lower_weight, upper_weight, zero pad
    input  logic [sbg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [sbg_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // band_number, band power, zero pad
    output logic [sbg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // floored
    output logic [0:0]                       m_axis_tuser
);

    localparam int BIN_COUNT = FFT_POINTS / 2 + 1;
    localparam int BIN_AW    = $clog2(BIN_COUNT);
    localparam int BAND_AW   = $clog2(MAX_BANDS);
    localparam int K_W       = sbg_pkg::IDX_W + 1;

    // input field unpack
    sbg_pkg::t_opcode              in_op;
    logic [sbg_pkg::IDX_W-1:0]     in_slot;
    logic [sbg_pkg::POW_W-1:0]     in_power;
    sbg_pkg::t_band                in_band;

    assign in_op          = sbg_pkg::t_opcode'(s_axis_tuser);
    assign in_slot        = s_axis_tdata[sbg_pkg::SLOT_LSB +: sbg_pkg::IDX_W];
    assign in_power       = s_axis_tdata[sbg_pkg::POWER_LSB +: sbg_pkg::POW_W];
    assign in_band.lo_bin = s_axis_tdata[sbg_pkg::LBIN_LSB +: sbg_pkg::IDX_W];
    assign in_band.up_bin = s_axis_tdata[sbg_pkg::UBIN_LSB +: sbg_pkg::IDX_W];
    assign in_band.lo_w   = s_axis_tdata[sbg_pkg::LWGT_LSB +: sbg_pkg::WGT_W];
    assign in_band.up_w   = s_axis_tdata[sbg_pkg::UWGT_LSB +: sbg_pkg::WGT_W];

    // storage
    logic [sbg_pkg::POW_W-1:0]     r_bin_mem [BIN_COUNT];
    sbg_pkg::t_band                r_band_mem [MAX_BANDS];
    logic [sbg_pkg::POW_W-1:0]     r_bin_q;
    sbg_pkg::t_band                r_band_q;

    // control and datapath registers
    sbg_pkg::t_state               r_state;
    sbg_pkg::t_state               n_state;
    logic                          r_rd_ok;
    logic                          r_pend;
    logic                          r_edge_up;
    logic [K_W-1:0]                r_k;
    logic [sbg_pkg::POW_W-1:0]     r_acc;
    logic [sbg_pkg::BAND_W-1:0]    r_band_num;
    logic                          r_m_valid;
    logic [sbg_pkg::POW_W-1:0]     r_m_power;
    logic [sbg_pkg::BAND_W-1:0]    r_m_band;
    logic                          r_m_floored;

    // decode and control
    logic                          in_fire;
    logic                          slot_bin_ok;
    logic                          slot_band_ok;
    logic                          bin_wr;
    logic                          band_wr;
    logic                          band_rd;
    logic                          bin_rd;
    logic [K_W-1:0]                rd_idx;
    logic                          rd_in_range;
    logic                          sum_issue;
    logic                          w_start;
    logic                          w_done;
    logic [sbg_pkg::POW_W-1:0]     w_term;
    logic                          out_load;
    logic [sbg_pkg::POW_W-1:0]     bin_val;
    logic [sbg_pkg::WGT_W-1:0]     edge_w;

    assign in_fire      = s_axis_tvalid && s_axis_tready;
    assign slot_bin_ok  = 32'(in_slot) < BIN_COUNT;
    assign slot_band_ok = 32'(in_slot) < MAX_BANDS;
    assign sum_issue    = (r_state == sbg_pkg::S_SUM)
                       && (r_k < {1'b0, r_band_q.up_bin});
    assign rd_in_range  = 32'(rd_idx) < BIN_COUNT;
    assign bin_val      = r_rd_ok ? r_bin_q : '0;
    assign edge_w       = r_edge_up ? r_band_q.up_w : r_band_q.lo_w;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbg_pkg::S_IDLE: begin
                if (in_fire && in_op == sbg_pkg::OP_COMPUTE && slot_band_ok) begin
                    n_state = sbg_pkg::S_TAB;
                end
            end
            sbg_pkg::S_TAB:     n_state = sbg_pkg::S_EDGE_RD;
            sbg_pkg::S_EDGE_RD: n_state = sbg_pkg::S_EDGE_GO;
            sbg_pkg::S_EDGE_GO: n_state = sbg_pkg::S_EDGE_WAIT;
            sbg_pkg::S_EDGE_WAIT: begin
                if (w_done) begin
                    n_state = r_edge_up ? sbg_pkg::S_SUM : sbg_pkg::S_EDGE_RD;
                end
            end
            sbg_pkg::S_SUM: begin
                if (!sum_issue && !r_pend) begin
                    n_state = sbg_pkg::S_OUT;
                end
            end
            sbg_pkg::S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = sbg_pkg::S_IDLE;
                end
            end
            default: n_state = sbg_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        bin_wr        = 1'b0;
        band_wr       = 1'b0;
        band_rd       = 1'b0;
        bin_rd        = 1'b0;
        rd_idx        = r_k;
        w_start       = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            sbg_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                bin_wr  = in_fire && in_op == sbg_pkg::OP_LOAD_BIN && slot_bin_ok;
                band_wr = in_fire && in_op == sbg_pkg::OP_LOAD_BAND && slot_band_ok;
                band_rd = in_fire && in_op == sbg_pkg::OP_COMPUTE && slot_band_ok;
            end
            sbg_pkg::S_EDGE_RD: begin
                bin_rd = 1'b1;
                rd_idx = r_edge_up ? {1'b0, r_band_q.up_bin} : {1'b0, r_band_q.lo_bin};
            end
            sbg_pkg::S_EDGE_GO: w_start = 1'b1;
            sbg_pkg::S_SUM: begin
                bin_rd = sum_issue;
                rd_idx = r_k;
            end
            sbg_pkg::S_OUT: out_load = !r_m_valid || m_axis_tready;
            default: ;
        endcase
    end

    // bin store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (bin_wr) begin
            r_bin_mem[BIN_AW'(in_slot)] <= in_power;
        end
        if (bin_rd && rd_in_range) begin
            r_bin_q <= r_bin_mem[BIN_AW'(rd_idx)];
        end
    end

    // band table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (band_wr) begin
            r_band_mem[BAND_AW'(in_slot)] <= in_band;
        end
        if (band_rd) begin
            r_band_q <= r_band_mem[BAND_AW'(in_slot)];
        end
    end

    // edge weighting unit
    sbg_weigh u_weigh (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_power  (bin_val),
        .i_weight (edge_w),
        .o_done   (w_done),
        .o_term   (w_term)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbg_pkg::S_IDLE;
            r_rd_ok   <= 1'b0;
            r_pend    <= 1'b0;
            r_edge_up <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= sum_issue;
            if (bin_rd) begin
                r_rd_ok <= rd_in_range;
            end
            if (r_state == sbg_pkg::S_TAB) begin
                r_edge_up <= 1'b0;
            end else if (r_state == sbg_pkg::S_EDGE_WAIT && w_done) begin
                r_edge_up <= 1'b1;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // accumulator and interior bin counter
    always_ff @(posedge i_clk) begin
        if (band_rd) begin
            r_band_num <= in_slot[sbg_pkg::BAND_W-1:0];
        end
        if (r_state == sbg_pkg::S_TAB) begin
            r_acc <= '0;
        end else if (r_state == sbg_pkg::S_EDGE_WAIT && w_done) begin
            r_acc <= sbg_pkg::sat_add(r_acc, w_term);
        end else if (r_state == sbg_pkg::S_SUM && r_pend) begin
            r_acc <= sbg_pkg::sat_add(r_acc, bin_val);
        end
        if (r_state == sbg_pkg::S_EDGE_WAIT && w_done && r_edge_up) begin
            r_k <= {1'b0, r_band_q.lo_bin} + K_W'(1);
        end else if (sum_issue) begin
            r_k <= r_k + K_W'(1);
        end
    end

    // output register, zero raised to one lsb
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_band    <= r_band_num;
            r_m_floored <= (r_acc == '0);
            r_m_power   <= (r_acc == '0) ? sbg_pkg::POW_W'(1) : r_acc;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{sbg_pkg::OUT_PAD_W{1'b0}}, r_m_power, r_m_band};
    assign m_axis_tuser  = r_m_floored;

endmodule

[design/sbg_checker.sv]
`timescale 1ns / 1ps

module sbg_checker #(
    parameter int MAX_BANDS = 128
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [sbg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [sbg_pkg::OP_W-1:0]         s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sbg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // band power never reads zero
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[sbg_pkg::OPOWER_LSB +: sbg_pkg::POW_W] != '0)
        else $error("zero band power");

    // a floored result carries exactly one lsb
    a_floor_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0]
        |-> m_axis_tdata[sbg_pkg::OPOWER_LSB +: sbg_pkg::POW_W] == sbg_pkg::POW_W'(1))
        else $error("floored result is not one lsb");

    // a valid compute transfer holds off the input while the band is summed
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == sbg_pkg::OP_COMPUTE
        && 32'(s_axis_tdata[sbg_pkg::SLOT_LSB +: sbg_pkg::IDX_W]) < MAX_BANDS
        |=> !s_axis_tready)
        else $error("input taken during band computation");

endmodule

bind spectral_band_grouping_top sbg_checker #(.MAX_BANDS(MAX_BANDS)) u_sbg_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int OP_W        = sbg_pkg::OP_W;
    localparam int IDX_W       = sbg_pkg::IDX_W;
    localparam int POW_W       = sbg_pkg::POW_W;
    localparam int WGT_W       = sbg_pkg::WGT_W;
    localparam int BAND_W      = sbg_pkg::BAND_W;
    localparam int FRAC_W      = sbg_pkg::FRAC_W;
    localparam int IN_TDATA_W  = sbg_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = sbg_pkg::OUT_TDATA_W;
    localparam int SLOT_LSB    = sbg_pkg::SLOT_LSB;
    localparam int POWER_LSB   = sbg_pkg::POWER_LSB;
    localparam int LBIN_LSB    = sbg_pkg::LBIN_LSB;
    localparam int UBIN_LSB    = sbg_pkg::UBIN_LSB;
    localparam int LWGT_LSB    = sbg_pkg::LWGT_LSB;
    localparam int UWGT_LSB    = sbg_pkg::UWGT_LSB;
    localparam int OBAND_LSB   = sbg_pkg::OBAND_LSB;
    localparam int OPOWER_LSB  = sbg_pkg::OPOWER_LSB;

    localparam int BIN_COUNT   = 1025;
    localparam int NUM_BANDS   = 128;
    localparam int BIN_IW      = 11;
    localparam int BAND_IW     = 7;
    localparam int ITEM_TARGET = 1950;
    localparam int SETTLE_CYC  = 64;
    localparam longint WATCHDOG_NS = 64'd100_000_000;
    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [POW_W-1:0] POW_MAX   = {POW_W{1'b1}};
    localparam logic [WGT_W-1:0] WGT_ONE   = 17'h10000;
    localparam logic [WGT_W-1:0] WGT_TOP   = 17'h1FFFF;

    // one input transfer, fields unpacked
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] slot;
        logic [POW_W-1:0] power;
        logic [IDX_W-1:0] lo_bin;
        logic [IDX_W-1:0] up_bin;
        logic [WGT_W-1:0] lo_w;
        logic [WGT_W-1:0] up_w;
    } t_item;

    // one band result
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [POW_W-1:0]  power;
        logic              floored;
    } t_band_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]         s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]              m_axis_tuser;

    spectral_band_grouping_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // predicted block state, updated on each accepted transfer
    logic [POW_W-1:0] bin_mem     [BIN_COUNT];
    logic [IDX_W-1:0] lo_edge_mem [NUM_BANDS];
    logic [IDX_W-1:0] up_edge_mem [NUM_BANDS];
    logic [WGT_W-1:0] lo_wgt_mem  [NUM_BANDS];
    logic [WGT_W-1:0] up_wgt_mem  [NUM_BANDS];

    // what the stimulus has written so far, so no unwritten entry is read
    bit gen_bin_ok  [BIN_COUNT];
    bit gen_band_ok [NUM_BANDS];
    int bands_loaded = 0;

    t_item        pending_items [$];
    t_band_result result_due [$];
    int           mismatch_count = 0;

    t_item        cur_item;
    t_band_result due_r;
    int           burst_left = 0;
    int           gap_left = 0;
    logic [31:0]  stall_cnt = '0;
    int           stall_mode = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // edge bin times weight, right shift by the weight fraction, kept wide
    function automatic logic [95:0] edge_share(input int idx, input logic [WGT_W-1:0] w);
        logic [95:0] p;
        logic [95:0] wx;
        if (idx >= BIN_COUNT)
            return '0;
        p  = 96'(bin_mem[BIN_IW'(idx)]);
        wx = 96'(w);
        return (p * wx) >> FRAC_W;
    endfunction

    // update predicted state; a compute on a valid band queues its result
    task automatic apply_item(input t_item it);
        int lo;
        int up;
        int k;
        logic [95:0] total;
        t_band_result r;
        logic [BAND_IW-1:0] b;
        b = it.slot[BAND_IW-1:0];
        case (it.op)
            sbg_pkg::OP_LOAD_BIN: begin
                if (it.slot < BIN_COUNT)
                    bin_mem[it.slot] = it.power;
            end
            sbg_pkg::OP_LOAD_BAND: begin
                if (it.slot < NUM_BANDS) begin
                    lo_edge_mem[b] = it.lo_bin;
                    up_edge_mem[b] = it.up_bin;
                    lo_wgt_mem[b]  = it.lo_w;
                    up_wgt_mem[b]  = it.up_w;
                end
            end
            sbg_pkg::OP_COMPUTE: begin
                if (it.slot < NUM_BANDS) begin
                    lo = lo_edge_mem[b];
                    up = up_edge_mem[b];
                    total = edge_share(lo, lo_wgt_mem[b])
                          + edge_share(up, up_wgt_mem[b]);
                    for (k = lo + 1; k < up && k < BIN_COUNT; k++)
                        total = total + bin_mem[BIN_IW'(k)];
                    // all terms are non-negative, so one clamp at the end matches
                    // clamping after every add
                    r.band    = it.slot[BAND_W-1:0];
                    r.floored = (total == 0);
                    if (total == 0)
                        r.power = POW_W'(1);
                    else if (total > POW_MAX)
                        r.power = POW_MAX;
                    else
                        r.power = total[POW_W-1:0];
                    result_due.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_item(input t_item it);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[SLOT_LSB +: IDX_W]  = it.slot;
        d[POWER_LSB +: POW_W] = it.power;
        d[LBIN_LSB +: IDX_W]  = it.lo_bin;
        d[UBIN_LSB +: IDX_W]  = it.up_bin;
        d[LWGT_LSB +: WGT_W]  = it.lo_w;
        d[UWGT_LSB +: WGT_W]  = it.up_w;
        return d;
    endfunction

    // every field random, the caller overrides what the opcode uses
    function automatic t_item junk_item();
        t_item it;
        it.op     = OP_W'($urandom_range(0, 3));
        it.slot   = IDX_W'($urandom_range(0, 2047));
        it.power  = {$urandom, $urandom};
        it.lo_bin = IDX_W'($urandom_range(0, 2047));
        it.up_bin = IDX_W'($urandom_range(0, 2047));
        it.lo_w   = WGT_W'($urandom_range(0, 131071));
        it.up_w   = WGT_W'($urandom_range(0, 131071));
        return it;
    endfunction

    function automatic logic [POW_W-1:0] rand_power();
        int unsigned pick;
        logic [POW_W-1:0] v;
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 8)
            v = '0;
        else if (pick < 14)
            v = POW_MAX;
        else if (pick < 60)
            v = v >> $urandom_range(24, 40);
        return v;
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return WGT_ONE;
        if (pick < 23)
            return '0;
        if (pick < 31)
            return WGT_TOP;
        return WGT_W'($urandom_range(0, 131071));
    endfunction

    task automatic push_bin(input int slot, input logic [POW_W-1:0] val);
        t_item it;
        it       = junk_item();
        it.op    = sbg_pkg::OP_LOAD_BIN;
        it.slot  = slot[IDX_W-1:0];
        it.power = val;
        pending_items.push_back(it);
        if (slot < BIN_COUNT)
            gen_bin_ok[BIN_IW'(slot)] = 1'b1;
    endtask

    // table load; first writes any bin the band would read that is still unwritten
    task automatic push_band(input int slot, input int lo, input int up,
                             input logic [WGT_W-1:0] lw, input logic [WGT_W-1:0] uw);
        t_item it;
        int k;
        if (slot < NUM_BANDS) begin
            for (k = lo; k <= up && k < BIN_COUNT; k++)
                if (!gen_bin_ok[BIN_IW'(k)])
                    push_bin(k, rand_power());
            if (lo < BIN_COUNT && !gen_bin_ok[BIN_IW'(lo)])
                push_bin(lo, rand_power());
            if (up < BIN_COUNT && !gen_bin_ok[BIN_IW'(up)])
                push_bin(up, rand_power());
        end
        it        = junk_item();
        it.op     = sbg_pkg::OP_LOAD_BAND;
        it.slot   = slot[IDX_W-1:0];
        it.lo_bin = lo[IDX_W-1:0];
        it.up_bin = up[IDX_W-1:0];
        it.lo_w   = lw;
        it.up_w   = uw;
        pending_items.push_back(it);
        if (slot < NUM_BANDS) begin
            if (!gen_band_ok[BAND_IW'(slot)])
                bands_loaded++;
            gen_band_ok[BAND_IW'(slot)] = 1'b1;
        end
    endtask

    task automatic push_compute(input int slot);
        t_item it;
        it      = junk_item();
        it.op   = sbg_pkg::OP_COMPUTE;
        it.slot = slot[IDX_W-1:0];
        pending_items.push_back(it);
    endtask

    task automatic push_unused_op();
        t_item it;
        it    = junk_item();
        it.op = OP_UNUSED;
        pending_items.push_back(it);
    endtask

    // random band table entry, mostly narrow bands inside the store
    task automatic push_random_band();
        int lo;
        int up;
        int pick;
        pick = $urandom_range(0, 99);
        lo = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 1024) : $urandom_range(1025, 2047);
        if (pick < 65) begin
            up = lo + $urandom_range(0, 12);
        end else if (pick < 80) begin
            up = $urandom_range(0, lo);
        end else if (pick < 95) begin
            up = lo + $urandom_range(13, 80);
        end else if (pick < 99) begin
            lo = $urandom_range(1000, 1024);
            up = $urandom_range(1025, 2047);
        end else begin
            up = lo + $urandom_range(81, 1023);
        end
        if (up > 2047)
            up = 2047;
        push_band($urandom_range(0, NUM_BANDS - 1), lo, up, rand_weight(), rand_weight());
    endtask

    // directed items: extremes, every opcode, ignored slots, edge cases
    task automatic build_directed();
        push_bin(0, '0);
        push_bin(1, '0);
        push_bin(2, POW_MAX);
        push_bin(3, 64'h0000_0001_0000_0000);
        push_bin(1024, POW_MAX);
        push_bin(1025, rand_power());
        push_bin(2047, rand_power());
        push_unused_op();
        // all zero power, raised to the floor
        push_band(0, 0, 1, WGT_ONE, WGT_ONE);
        // weights above one on an all-ones lower bin, saturates
        push_band(1, 2, 3, WGT_TOP, WGT_TOP);
        // reversed edges, smallest weight
        push_band(2, 3, 0, 17'd1, 17'd1);
        // both edges beyond the store
        push_band(3, 2047, 2000, rand_weight(), rand_weight());
        // last bin with interior beyond the store
        push_band(4, 1024, 1030, WGT_ONE, rand_weight());
        // equal edges, highest band
        push_band(127, 3, 3, WGT_ONE, WGT_ONE);
        push_band(128, 0, 5, WGT_ONE, WGT_ONE);
        push_band(2047, 1, 2, WGT_ONE, WGT_ONE);
        push_compute(0);
        push_compute(1);
        push_compute(2);
        push_compute(3);
        push_compute(4);
        push_compute(127);
        push_compute(128);
        push_compute(2047);
    endtask

    task automatic build_random();
        int pick;
        int s;
        while (pending_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                push_bin($urandom_range(0, BIN_COUNT - 1), rand_power());
            end else if (pick < 45 || bands_loaded == 0) begin
                push_random_band();
            end else if (pick < 90) begin
                do
                    s = $urandom_range(0, NUM_BANDS - 1);
                while (!gen_band_ok[BAND_IW'(s)]);
                push_compute(s);
            end else begin
                // ignored transfers
                case ($urandom_range(0, 3))
                    0: push_unused_op();
                    1: push_bin($urandom_range(BIN_COUNT, 2047), rand_power());
                    2: push_band($urandom_range(NUM_BANDS, 2047), $urandom_range(0, 2047),
                                 $urandom_range(0, 2047), rand_weight(), rand_weight());
                    default: push_compute($urandom_range(NUM_BANDS, 2047));
                endcase
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_item(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end else begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata  <= pack_item(cur_item);
                    s_axis_tuser  <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: stall pattern picked at random whenever the stall counter's low byte wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_cnt     <= '0;
            stall_mode    <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt[7:0] == 8'hFF)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= stall_cnt[0];
                2: m_axis_tready <= ($urandom_range(0, 9) < 7);
                default: m_axis_tready <= (stall_cnt[2:0] == 3'd0);
            endcase
        end
    end

    // result check against the oldest pending band
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_due.size() == 0) begin
                report_mismatch("result transfer with no band pending");
            end else begin
                due_r = result_due.pop_front();
                if (m_axis_tdata[OBAND_LSB +: BAND_W] != due_r.band)
                    report_mismatch($sformatf("band_number got %0d want %0d",
                                    m_axis_tdata[OBAND_LSB +: BAND_W], due_r.band));
                if (m_axis_tdata[OPOWER_LSB +: POW_W] != due_r.power)
                    report_mismatch($sformatf("band %0d power got %h want %h", due_r.band,
                                    m_axis_tdata[OPOWER_LSB +: POW_W], due_r.power));
                if (m_axis_tuser[0] != due_r.floored)
                    report_mismatch($sformatf("band %0d floored got %0d want %0d", due_r.band,
                                    m_axis_tuser[0], due_r.floored));
            end
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (result_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("timeout, %0d results still pending", result_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
